[hw/rtl/art_pkg.sv]
// Shared types, constants and codes of the address region table.
package art_pkg;

   // Table depth and page size
   localparam int TABLE_DEPTH = 32;
   localparam int PAGE_BITS   = 12;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [31:0] PG_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);
   localparam logic [32:0] PG_SIZE = 33'(64'd1 << PAGE_BITS);

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_TOP  = 1'b1;

   localparam logic [31:0] USER_BASE_RST = 32'h0020_0000;
   localparam logic [31:0] USER_TOP_RST  = 32'hB000_0000;

   // Command codes
   localparam logic [2:0] CMD_MAP   = 3'd0;
   localparam logic [2:0] CMD_UNMAP = 3'd1;
   localparam logic [2:0] CMD_CHECK = 3'd2;
   localparam logic [2:0] CMD_FIND  = 3'd3;
   localparam logic [2:0] CMD_FREE  = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_MISS    = 2'd3;

   // Flag bits
   localparam int FL_READ_BIT  = 0;
   localparam int FL_WRITE_BIT = 1;
   localparam int FL_STACK_BIT = 3;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr;
      logic [31:0] length;
      logic [3:0]  flags;
      logic        write_access;
   } art_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_addr;
      logic [31:0] region_end;
      logic [3:0]  region_flags;
   } art_rsp_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
      logic [3:0]  fl;
   } art_entry_type;

   localparam int ENTRY_W = $bits(art_entry_type);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_SHIFT   = 5'b00100,
      ST_COMPACT = 5'b01000,
      ST_DONE    = 5'b10000
   } art_state_type;

endpackage

[hw/rtl/art_ram.sv]
// Generic simple dual-port RAM with registered read and write-through.
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read with forwarding of a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (we && (waddr == raddr)) begin
         rdata <= wdata;
      end else begin
         rdata <= mem[raddr];
      end
   end

endmodule

[hw/rtl/address_region_table_core.sv]
// Top level of the address region table: sequencer around the region memory.
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_stall | art_req_type
//  rsp     | out       | rsp_valid/rsp_stall | art_rsp_type
//  csr     | in        | csr_we              | index + 32-bit data
//
// An item is accepted, the scan visits the regions one at a time, and the result is
// delivered last; map and split first move the regions above the hole up one place and
// insert, and unmap compacts from the first hit to the end of the table, all paced by
// the one region memory.
// Reset clears the region count; the memory itself is never cleared.
// A waiting result does not block the next accept; only its delivery waits.
module address_region_table_core
   import art_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  art_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output art_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   art_state_type state_ff, state_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      len_ff, len_in;
   logic [3:0]       flags_ff, flags_in;
   logic             wr_ff, wr_in;
   logic [31:0]      s_ff, s_in;
   logic [31:0]      e_ff, e_in;
   logic [32:0]      ce_ff, ce_in;
   logic [31:0]      cs_ff, cs_in;
   logic [31:0]      fs_ff, fs_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   art_entry_type    new_ff, new_in;
   art_rsp_type      res_ff, res_in;
   art_rsp_type      rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      base_ff, base_in;
   logic [31:0]      top_ff, top_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   art_entry_type    mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;
   art_entry_type    ent;

   logic [31:0] rq_s;
   logic [33:0] rq_e;
   logic [32:0] rq_ce;
   logic        rq_rng_ok;
   logic        rq_chk_ok;
   logic        full;
   logic        at_end;
   logic        perm_ok;
   logic        guard_hit;
   logic [31:0] fs_nx;
   logic        rsp_free;

   art_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(idx_in[IDX_W-1:0]),
      .rdata(mem_rdata)
   );

   assign ent       = art_entry_type'(mem_rdata);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign full      = (cnt_ff == CNT_W'(TABLE_DEPTH));
   assign at_end    = (idx_ff == cnt_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Round the request range out to pages, and test it and the exact range against the user range
   always_comb begin
      rq_s  = req_data.addr & ~PG_MASK;
      rq_e  = ({2'b00, req_data.addr} + {2'b00, req_data.length} + {2'b00, PG_MASK})
              & ~{2'b00, PG_MASK};
      rq_ce = {1'b0, req_data.addr} + {1'b0, req_data.length};
      rq_rng_ok = (base_ff <= rq_s) && ({2'b00, rq_s} < rq_e) && (rq_e <= {2'b00, top_ff});
      rq_chk_ok = (base_ff <= req_data.addr) && ({1'b0, req_data.addr} < rq_ce)
                  && (rq_ce <= {1'b0, top_ff});
   end

   // Permission and stack guard of the entry under the access cursor
   always_comb begin
      perm_ok   = wr_ff ? ent.fl[FL_WRITE_BIT] : ent.fl[FL_READ_BIT];
      guard_hit = wr_ff && ent.fl[FL_STACK_BIT]
                  && ({1'b0, cs_ff} < ({1'b0, ent.lo} + PG_SIZE));
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      flags_in     = flags_ff;
      wr_in        = wr_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      ce_in        = ce_ff;
      cs_in        = cs_ff;
      fs_in        = fs_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      base_in      = base_ff;
      top_in       = top_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[IDX_W-1:0];
      mem_wdata    = ent;
      fs_nx        = fs_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_USER_BASE: base_in = csr_wdata;
            CSR_USER_TOP:  top_in  = csr_wdata;
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               addr_in  = req_data.addr;
               len_in   = req_data.length;
               flags_in = req_data.flags;
               wr_in    = req_data.write_access;
               s_in     = rq_s;
               e_in     = rq_e[31:0];
               ce_in    = rq_ce;
               cs_in    = req_data.addr;
               res_in   = '{STAT_INVALID, 32'd0, 32'd0, 4'd0};
               idx_in   = '0;
               state_in = ST_DONE;
               unique case (req_data.cmd)
                  CMD_MAP, CMD_UNMAP: begin
                     if (rq_rng_ok) state_in = ST_SCAN;
                  end
                  CMD_CHECK: begin
                     if (rq_chk_ok) state_in = ST_SCAN;
                  end
                  CMD_FIND: state_in = ST_SCAN;
                  CMD_FREE: begin
                     if ((req_data.length != 32'd0) && (req_data.length <= top_ff)) begin
                        fs_in = top_ff - req_data.length;
                        if (cnt_ff == '0) begin
                           if (fs_in >= base_ff) begin
                              res_in = '{STAT_OK, fs_in, 32'd0, 4'd0};
                           end
                        end else begin
                           idx_in   = cnt_ff - CNT_W'(1);
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            unique case (cmd_ff)
               CMD_MAP: begin
                  priority if (at_end || (ent.hi > s_ff)) begin
                     if (!at_end && (e_ff > ent.lo)) begin
                        res_in.status = STAT_INVALID;
                        state_in = ST_DONE;
                     end else if (full) begin
                        res_in.status = STAT_FULL;
                        state_in = ST_DONE;
                     end else begin
                        // Open a hole at the cursor for the new region
                        pos_in   = idx_ff;
                        wptr_in  = cnt_ff;
                        idx_in   = cnt_ff - CNT_W'(1);
                        new_in   = '{s_ff, e_ff, flags_ff};
                        res_in   = '{STAT_OK, s_ff, e_ff, flags_ff};
                        state_in = ST_SHIFT;
                     end
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               CMD_UNMAP: begin
                  priority if (at_end || (e_ff <= ent.lo && ent.hi > s_ff)) begin
                     res_in   = '{STAT_OK, s_ff, e_ff, 4'd0};
                     state_in = ST_DONE;
                  end else if (ent.hi <= s_ff) begin
                     idx_in = idx_ff + CNT_W'(1);
                  end else if ((ent.lo < s_ff) && (e_ff < ent.hi)) begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                        state_in = ST_DONE;
                     end else begin
                        // Trim the upper part in place, insert the lower part
                        mem_we    = 1'b1;
                        mem_waddr = idx_ff[IDX_W-1:0];
                        mem_wdata = '{e_ff, ent.hi, ent.fl};
                        pos_in    = idx_ff;
                        wptr_in   = cnt_ff;
                        idx_in    = cnt_ff - CNT_W'(1);
                        new_in    = '{ent.lo, s_ff, ent.fl};
                        res_in    = '{STAT_OK, s_ff, e_ff, 4'd0};
                        state_in  = ST_SHIFT;
                     end
                  end else begin
                     wptr_in  = idx_ff;
                     res_in   = '{STAT_OK, s_ff, e_ff, 4'd0};
                     state_in = ST_COMPACT;
                  end
               end
               CMD_CHECK: begin
                  priority if (at_end) begin
                     res_in.status = STAT_MISS;
                     state_in = ST_DONE;
                  end else if (ent.hi <= cs_ff) begin
                     idx_in = idx_ff + CNT_W'(1);
                  end else if ((cs_ff < ent.lo) || !perm_ok || guard_hit) begin
                     res_in.status = STAT_MISS;
                     state_in = ST_DONE;
                  end else if ({1'b0, ent.hi} >= ce_ff) begin
                     res_in.status = STAT_OK;
                     state_in = ST_DONE;
                  end else begin
                     cs_in  = ent.hi;
                     idx_in = idx_ff + CNT_W'(1);
                  end
               end
               CMD_FIND: begin
                  priority if (at_end) begin
                     res_in.status = STAT_MISS;
                     state_in = ST_DONE;
                  end else if (ent.hi <= addr_ff) begin
                     idx_in = idx_ff + CNT_W'(1);
                  end else if (ent.lo <= addr_ff) begin
                     res_in   = '{STAT_OK, ent.lo, ent.hi, ent.fl};
                     state_in = ST_DONE;
                  end else begin
                     res_in.status = STAT_MISS;
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  // Free area: walk down from the top
                  priority if (fs_ff >= ent.hi) begin
                     res_in   = '{STAT_OK, fs_ff, 32'd0, 4'd0};
                     state_in = ST_DONE;
                  end else if (({1'b0, fs_ff} + {1'b0, len_ff}) > {1'b0, ent.lo}
                               && (len_ff >= ent.lo)) begin
                     res_in.status = STAT_INVALID;
                     state_in = ST_DONE;
                  end else begin
                     if (({1'b0, fs_ff} + {1'b0, len_ff}) > {1'b0, ent.lo}) begin
                        fs_nx = ent.lo - len_ff;
                     end
                     fs_in = fs_nx;
                     if (idx_ff == '0) begin
                        if (fs_nx >= base_ff) begin
                           res_in = '{STAT_OK, fs_nx, 32'd0, 4'd0};
                        end
                        state_in = ST_DONE;
                     end else begin
                        idx_in = idx_ff - CNT_W'(1);
                     end
                  end
               end
            endcase
         end

         ST_SHIFT: begin
            mem_we = 1'b1;
            if (wptr_ff == pos_ff) begin
               mem_waddr = pos_ff[IDX_W-1:0];
               mem_wdata = new_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
               state_in  = ST_DONE;
            end else begin
               // Move one entry up
               mem_waddr = wptr_ff[IDX_W-1:0];
               mem_wdata = ent;
               wptr_in   = wptr_ff - CNT_W'(1);
               idx_in    = idx_ff - CNT_W'(1);
            end
         end

         ST_COMPACT: begin
            if (at_end) begin
               cnt_in   = wptr_ff;
               state_in = ST_DONE;
            end else begin
               // Trim, keep or drop, writing survivors down at the write pointer
               mem_waddr = wptr_ff[IDX_W-1:0];
               priority if (ent.lo >= e_ff) begin
                  mem_we = 1'b1;
               end else if (ent.lo < s_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{ent.lo, s_ff, ent.fl};
               end else if (e_ff < ent.hi) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{e_ff, ent.hi, ent.fl};
               end else begin
                  mem_we = 1'b0;
               end
               if (mem_we) wptr_in = wptr_ff + CNT_W'(1);
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= USER_BASE_RST;
         top_ff       <= USER_TOP_RST;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         idx_ff       <= idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      len_ff   <= len_in;
      flags_ff <= flags_in;
      wr_ff    <= wr_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      ce_ff    <= ce_in;
      cs_ff    <= cs_in;
      fs_ff    <= fs_in;
      wptr_ff  <= wptr_in;
      pos_ff   <= pos_in;
      new_ff   <= new_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("region count above table depth");

   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > $past(cnt_ff)) |-> ($past(state_ff) == ST_SHIFT))
      else $error("region count grew outside an insert");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised without a finished command");
`endif

endmodule
